>>> rtl/core/fp_register_file_format_tagged_unit_macros.svh
// Assertion helpers used by the register file RTL.
`ifndef FP_REGISTER_FILE_FORMAT_TAGGED_UNIT_MACROS_SVH
`define FP_REGISTER_FILE_FORMAT_TAGGED_UNIT_MACROS_SVH

// cond_a true at an edge implies cond_c true at the same edge
`define FPRF_ASSERT_IMPL(lbl, clk_i, rstn_i, cond_a, cond_c) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) \
        (cond_a) |-> (cond_c)) else $error("fprf check failed");

// cond_a true at an edge implies cond_c true at the next edge
`define FPRF_ASSERT_NEXT(lbl, clk_i, rstn_i, cond_a, cond_c) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) \
        (cond_a) |=> (cond_c)) else $error("fprf check failed");

`endif

>>> rtl/core/fprf_pkg.sv
package fprf_pkg;

    localparam int NUM_REGS   = 32;
    localparam int DATA_W     = 64;
    localparam int HALF_W     = 32;
    localparam int REG_IDX_W  = 5;
    localparam int BANK_DEPTH = (NUM_REGS + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic [HALF_W-1:0] QNAN_SINGLE = 32'h7FBF_FFFF;
    localparam logic [HALF_W-1:0] QNAN_WORD   = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] QNAN_DOUBLE = 64'h7FF7_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] QNAN_LONG   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [HALF_W-1:0] FILL_HIGH   = 32'hDEAD_C0DE;

    typedef enum logic [2:0] {
        FMT_UNINT   = 3'd0,
        FMT_SGL     = 3'd1,
        FMT_DBL     = 3'd2,
        FMT_W32     = 3'd3,
        FMT_L64     = 3'd4,
        FMT_UNK     = 3'd5,
        FMT_UNINT32 = 3'd6,
        FMT_UNINT64 = 3'd7
    } fmt_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_RESERVED = 2'd1,
        ST_BADFMT   = 2'd2
    } status_t;

    typedef enum logic {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef struct packed {
        func_t                func;
        logic [REG_IDX_W-1:0] reg_index;
        fmt_t                 format;
        logic [DATA_W-1:0]    write_value;
    } item_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        status_t           status;
        logic              format_conflict;
    } result_t;

    typedef struct packed {
        logic               data_en;
        logic               tag_en;
        logic [BANK_AW-1:0] addr;
        logic [DATA_W-1:0]  data;
        fmt_t               tag;
    } bank_wr_t;

endpackage

>>> rtl/core/fprf_bank.sv
// One bank (even or odd register numbers): data, valid bits and format tags.
module fprf_bank
    import fprf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [BANK_AW-1:0] rd_addr,
    output logic [DATA_W-1:0]  rd_data,
    output fmt_t               rd_tag,
    input  bank_wr_t           wr
);

    logic [DATA_W-1:0]     data_reg [BANK_DEPTH];
    logic [BANK_DEPTH-1:0] vld_reg;
    fmt_t                  tag_reg  [BANK_DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int i = 0; i < BANK_DEPTH; i++)
            begin
                tag_reg[i] <= FMT_UNINT;
            end
        end
        else
        begin
            if (wr.data_en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (wr.tag_en)
            begin
                tag_reg[wr.addr] <= wr.tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.data_en)
        begin
            data_reg[wr.addr] <= wr.data;
        end
    end

    // never-written entries read as zero
    assign rd_data = vld_reg[rd_addr] ? data_reg[rd_addr] : '0;
    assign rd_tag  = tag_reg[rd_addr];

endmodule

>>> rtl/core/fprf_access.sv
// Single-pass access logic: tag update, read data select, write steering.
module fprf_access
    import fprf_pkg::*;
(
    input  item_t              item,
    input  logic               fire,
    input  logic               wide,
    output logic [BANK_AW-1:0] rd_addr,
    input  logic [DATA_W-1:0]  even_data,
    input  fmt_t               even_tag,
    input  logic [DATA_W-1:0]  odd_data,
    input  fmt_t               odd_tag,
    output bank_wr_t           even_wr,
    output bank_wr_t           odd_wr,
    output result_t            res
);

    logic [REG_IDX_W:0]  r_ext;
    logic [REG_IDX_W:0]  half;
    logic [REG_IDX_W:0]  half_up;
    logic                odd_sel;
    logic                in_range;
    logic                pair_hi;
    fmt_t                own_tag;
    logic [DATA_W-1:0]   own_data;
    logic [HALF_W-1:0]   hi32;
    fmt_t                f_req;
    fmt_t                f_eff;
    fmt_t                t_adopt;
    fmt_t                t_new;
    fmt_t                w_tag;
    logic                conflict;
    bank_wr_t            own_wr;
    bank_wr_t            mate_wr;
    logic [DATA_W-1:0]   val;
    status_t             st;

    assign r_ext    = {1'b0, item.reg_index};
    assign half     = r_ext >> 1;
    assign half_up  = half + 1'b1;
    assign odd_sel  = item.reg_index[0];
    assign in_range = int'(r_ext) < NUM_REGS;
    assign pair_hi  = (int'(r_ext) + 1) < NUM_REGS;
    assign rd_addr  = half[BANK_AW-1:0];
    assign own_tag  = odd_sel ? odd_tag  : even_tag;
    assign own_data = odd_sel ? odd_data : even_data;
    assign hi32     = pair_hi ? odd_data[HALF_W-1:0] : '0;
    assign f_req    = item.format;

    // read-side tag resolution
    assign f_eff    = (f_req == FMT_UNINT || f_req == FMT_UNK) ? own_tag : f_req;
    assign t_adopt  = (own_tag == FMT_UNINT) ? f_eff : own_tag;
    assign conflict = (f_eff != t_adopt);
    assign t_new    = conflict ? FMT_UNK : t_adopt;

    always_comb
    begin
        own_wr       = '0;
        mate_wr      = '0;
        own_wr.addr  = half[BANK_AW-1:0];
        mate_wr.addr = odd_sel ? half_up[BANK_AW-1:0] : half[BANK_AW-1:0];
        own_wr.tag   = FMT_UNINT;
        mate_wr.tag  = FMT_UNINT;
        val          = '0;
        st           = ST_OK;
        w_tag        = FMT_UNINT;

        if (item.func == FUNC_READ)
        begin
            own_wr.tag_en = 1'b1;
            own_wr.tag    = t_new;
            if (t_new == FMT_UNK)
            begin
                case (f_eff)
                    FMT_SGL: val = {{HALF_W{1'b0}}, QNAN_SINGLE};
                    FMT_DBL: val = QNAN_DOUBLE;
                    FMT_W32: val = {{HALF_W{1'b0}}, QNAN_WORD};
                    FMT_L64: val = QNAN_LONG;
                    default: st  = ST_BADFMT;
                endcase
            end
            else if (f_eff inside {FMT_SGL, FMT_W32})
            begin
                val = {{HALF_W{1'b0}}, own_data[HALF_W-1:0]};
            end
            else if (f_eff inside {FMT_UNINT, FMT_DBL, FMT_L64})
            begin
                if (wide)
                    val = own_data;
                else if (!odd_sel)
                    val = {hi32, even_data[HALF_W-1:0]};
                else
                    st = ST_RESERVED;
            end
            else
            begin
                st = ST_BADFMT;
            end
        end
        else
        begin
            if (f_req inside {FMT_SGL, FMT_W32, FMT_UNINT32})
            begin
                w_tag          = (f_req == FMT_UNINT32) ? FMT_UNINT : f_req;
                own_wr.data_en = 1'b1;
                own_wr.tag_en  = 1'b1;
                own_wr.tag     = w_tag;
                own_wr.data    = {wide ? FILL_HIGH : {HALF_W{1'b0}},
                                  item.write_value[HALF_W-1:0]};
            end
            else if (f_req inside {FMT_UNINT, FMT_DBL, FMT_L64, FMT_UNINT64})
            begin
                w_tag = (f_req == FMT_UNINT64) ? FMT_UNINT : f_req;
                if (wide)
                begin
                    own_wr.data_en = 1'b1;
                    own_wr.tag_en  = 1'b1;
                    own_wr.tag     = w_tag;
                    own_wr.data    = item.write_value;
                end
                else if (!odd_sel)
                begin
                    own_wr.data_en  = 1'b1;
                    own_wr.tag_en   = 1'b1;
                    own_wr.tag      = w_tag;
                    own_wr.data     = {{HALF_W{1'b0}}, item.write_value[HALF_W-1:0]};
                    mate_wr.data_en = pair_hi;
                    mate_wr.tag_en  = pair_hi;
                    mate_wr.tag     = w_tag;
                    mate_wr.data    = {{HALF_W{1'b0}}, item.write_value[DATA_W-1:HALF_W]};
                end
                else
                begin
                    // odd half of a pair: poison both tags, keep data
                    own_wr.tag_en  = 1'b1;
                    own_wr.tag     = FMT_UNK;
                    mate_wr.tag_en = pair_hi;
                    mate_wr.tag    = FMT_UNK;
                    st             = ST_RESERVED;
                end
            end
            else
            begin
                own_wr.tag_en = 1'b1;
                own_wr.tag    = FMT_UNK;
                st            = ST_BADFMT;
            end
        end

        if (st != ST_OK)
            val = '0;

        if (!(fire && in_range))
        begin
            own_wr.data_en  = 1'b0;
            own_wr.tag_en   = 1'b0;
            mate_wr.data_en = 1'b0;
            mate_wr.tag_en  = 1'b0;
        end

        res.read_value      = in_range ? val : '0;
        res.status          = in_range ? st : ST_OK;
        res.format_conflict = in_range && (item.func == FUNC_READ) && conflict;
    end

    assign even_wr = odd_sel ? mate_wr : own_wr;
    assign odd_wr  = odd_sel ? own_wr  : mate_wr;

endmodule

>>> rtl/core/fp_register_file_format_tagged_unit.sv
// Floating-point register file with a format tag per register. One access
// (read or write) is taken per transfer on the req channel and gives exactly
// one transfer on the rsp channel. Throughput is one access per clock while
// rsp_ready is high. The req transfer loads the input register; the access
// then moves into the result register and raises rsp_valid. While rsp_ready
// is low both registers hold and req_ready drops once both are full. The tag
// read-modify-write and the data banks are updated in the same cycle the
// access moves into the result register, so the next access already sees
// them. Registers are held in an even and an odd bank so a 32-bit-mode pair
// reads and writes both halves at one bank address each. wide_registers
// (cfg_wr_data, reset 1) selects 64-bit registers; write it only while no
// access is in flight. Reset makes all data read as zero (per-entry valid
// bits) and all tags uninterpreted at once; no clearing pass is needed.

`include "fp_register_file_format_tagged_unit_macros.svh"

module fp_register_file_format_tagged_unit
    import fprf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,

    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 func,
    input  logic [REG_IDX_W-1:0] reg_index,
    input  logic [2:0]           format,
    input  logic [DATA_W-1:0]    write_value,

    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [DATA_W-1:0]    read_value,
    output logic [1:0]           status,
    output logic                 format_conflict
);

    logic               wide_reg;
    logic               s1_vld_reg;
    item_t              item_reg;
    item_t              item_next;
    logic               rsp_vld_reg;
    result_t            rsp_reg;
    result_t            rsp_next;

    logic               out_free;
    logic               s1_go;

    logic [BANK_AW-1:0] rd_addr;
    logic [DATA_W-1:0]  even_data;
    logic [DATA_W-1:0]  odd_data;
    fmt_t               even_tag;
    fmt_t               odd_tag;
    bank_wr_t           even_wr;
    bank_wr_t           odd_wr;

    // result register frees when empty or being taken this cycle
    assign out_free  = !rsp_vld_reg || rsp_ready;
    assign s1_go     = s1_vld_reg && out_free;
    assign req_ready = !s1_vld_reg || out_free;

    assign item_next.func        = func_t'(func);
    assign item_next.reg_index   = reg_index;
    assign item_next.format      = fmt_t'(format);
    assign item_next.write_value = write_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg    <= 1'b1;
            s1_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                wide_reg <= cfg_wr_data;
            if (req_ready)
                s1_vld_reg <= req_valid;
            if (out_free)
                rsp_vld_reg <= s1_vld_reg;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            item_reg <= item_next;
        if (s1_go)
            rsp_reg <= rsp_next;
    end

    fprf_access u_access (
        .item      (item_reg),
        .fire      (s1_go),
        .wide      (wide_reg),
        .rd_addr   (rd_addr),
        .even_data (even_data),
        .even_tag  (even_tag),
        .odd_data  (odd_data),
        .odd_tag   (odd_tag),
        .even_wr   (even_wr),
        .odd_wr    (odd_wr),
        .res       (rsp_next)
    );

    fprf_bank u_even_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (even_data),
        .rd_tag  (even_tag),
        .wr      (even_wr)
    );

    fprf_bank u_odd_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (odd_data),
        .rd_tag  (odd_tag),
        .wr      (odd_wr)
    );

    assign rsp_valid       = rsp_vld_reg;
    assign read_value      = rsp_reg.read_value;
    assign status          = rsp_reg.status;
    assign format_conflict = rsp_reg.format_conflict;

    // a faulting access never returns data
    `FPRF_ASSERT_IMPL(a_fault_zero, clk, rst_n, rsp_valid && status != ST_OK, read_value == '0)
    // status code 3 is never produced
    `FPRF_ASSERT_IMPL(a_status_legal, clk, rst_n, rsp_valid, status != 2'd3)
    // a conflict returns a NaN or a format fault, never a reserved status
    `FPRF_ASSERT_IMPL(a_conf_not_rsvd, clk, rst_n, rsp_valid && format_conflict,
                      status != ST_RESERVED)
    // a pending access is not dropped while the result register is blocked
    `FPRF_ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_vld_reg && !out_free, s1_vld_reg)

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import fprf_pkg::*;

    // Shadow copy of the register file. Each accepted request is applied
    // to the shadow state in acceptance order and the response it should
    // produce is queued; responses are checked oldest first.
    class fpr_scoreboard;
        logic [DATA_W-1:0] regs [NUM_REGS];
        fmt_t              tags [NUM_REGS];
        bit                wide;
        result_t           expected_q [$];
        int                errors;

        function new();
            foreach (regs[i])
            begin
                regs[i] = '0;
                tags[i] = FMT_UNINT;
            end
            wide   = 1'b1;
            errors = 0;
        endfunction

        function automatic bit is_pair_format(fmt_t f);
            return f == FMT_UNINT || f == FMT_DBL || f == FMT_L64;
        endfunction

        function automatic result_t read_reg(int unsigned r, fmt_t f);
            result_t res;
            logic [HALF_W-1:0] hi;
            res.read_value      = '0;
            res.status          = ST_OK;
            res.format_conflict = 1'b0;
            if (f == FMT_UNINT || f == FMT_UNK)
                f = tags[r];
            if (tags[r] == FMT_UNINT)
                tags[r] = f;
            if (f != tags[r])
            begin
                tags[r]             = FMT_UNK;
                res.format_conflict = 1'b1;
            end
            if (tags[r] == FMT_UNK)
            begin
                case (f)
                    FMT_SGL: res.read_value = {32'h0, QNAN_SINGLE};
                    FMT_DBL: res.read_value = QNAN_DOUBLE;
                    FMT_W32: res.read_value = {32'h0, QNAN_WORD};
                    FMT_L64: res.read_value = QNAN_LONG;
                    default: res.status     = ST_BADFMT;
                endcase
            end
            else if (f == FMT_SGL || f == FMT_W32)
                res.read_value = {32'h0, regs[r][HALF_W-1:0]};
            else if (is_pair_format(f))
            begin
                if (wide)
                    res.read_value = regs[r];
                else if (r % 2 == 0)
                begin
                    hi = (r + 1 < NUM_REGS) ? regs[r + 1][HALF_W-1:0] : '0;
                    res.read_value = {hi, regs[r][HALF_W-1:0]};
                end
                else
                    res.status = ST_RESERVED;
            end
            else
                res.status = ST_BADFMT;
            if (res.status != ST_OK)
                res.read_value = '0;
            return res;
        endfunction

        function automatic status_t write_reg(int unsigned r, fmt_t f, logic [DATA_W-1:0] v);
            fmt_t t;
            t = (f == FMT_UNINT32 || f == FMT_UNINT64) ? FMT_UNINT : f;
            if (f == FMT_SGL || f == FMT_W32 || f == FMT_UNINT32)
            begin
                regs[r] = wide ? {FILL_HIGH, v[HALF_W-1:0]} : {32'h0, v[HALF_W-1:0]};
                tags[r] = t;
                return ST_OK;
            end
            if (is_pair_format(f) || f == FMT_UNINT64)
            begin
                if (wide)
                begin
                    regs[r] = v;
                    tags[r] = t;
                    return ST_OK;
                end
                if (r % 2 == 0)
                begin
                    regs[r] = {32'h0, v[HALF_W-1:0]};
                    tags[r] = t;
                    if (r + 1 < NUM_REGS)
                    begin
                        regs[r + 1] = {32'h0, v[DATA_W-1:HALF_W]};
                        tags[r + 1] = t;
                    end
                    return ST_OK;
                end
                // odd register with a paired format: no data, both tags poisoned
                tags[r] = FMT_UNK;
                if (r + 1 < NUM_REGS)
                    tags[r + 1] = FMT_UNK;
                return ST_RESERVED;
            end
            tags[r] = FMT_UNK;
            return ST_BADFMT;
        endfunction

        function automatic void note_access(func_t fn, int unsigned r, fmt_t f,
                                            logic [DATA_W-1:0] v);
            result_t res;
            res.read_value      = '0;
            res.status          = ST_OK;
            res.format_conflict = 1'b0;
            if (r < NUM_REGS)
            begin
                if (fn == FUNC_WRITE)
                    res.status = write_reg(r, f, v);
                else
                    res = read_reg(r, f);
            end
            expected_q.push_back(res);
        endfunction

        task automatic report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
            if (errors < 30)
                $display("%0t: %s expected %h got %h", $time, what, want, got);
            errors++;
        endtask

        task automatic check_result(logic [DATA_W-1:0] val, logic [1:0] st, logic cf);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report("response with no request outstanding", '0, val);
                return;
            end
            want = expected_q.pop_front();
            if (val !== want.read_value)
                report("read_value", want.read_value, val);
            if (st !== want.status)
                report("status", DATA_W'(want.status), DATA_W'(st));
            if (cf !== want.format_conflict)
                report("format_conflict", DATA_W'(want.format_conflict), DATA_W'(cf));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n        = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    logic                 cfg_wr_data  = 1'b1;
    logic                 req_valid    = 1'b0;
    logic                 req_ready;
    logic                 req_func     = 1'b0;
    logic [REG_IDX_W-1:0] req_reg      = '0;
    logic [2:0]           req_format   = '0;
    logic [DATA_W-1:0]    req_value    = '0;
    logic                 rsp_valid;
    logic                 rsp_ready    = 1'b0;
    logic [DATA_W-1:0]    rsp_value;
    logic [1:0]           rsp_status;
    logic                 rsp_conflict;

    // idle percentages for the two sides, changed per phase
    int unsigned   send_idle_pct = 0;
    int unsigned   rsp_stall_pct = 0;
    bit            cur_wide      = 1'b1;
    fpr_scoreboard sb            = new();

    fp_register_file_format_tagged_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .func            (req_func),
        .reg_index       (req_reg),
        .format          (req_format),
        .write_value     (req_value),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .read_value      (rsp_value),
        .status          (rsp_status),
        .format_conflict (rsp_conflict)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop, set far beyond the length of the real run even with both sides
    // idling.
    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Response side: sample the transfer at the edge, then pick ready for the
    // next cycle. Values read here are the ones settled before the edge.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp_value, rsp_status, rsp_conflict);
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // One request transfer. Valid is only lowered for idle cycles, so back to
    // back requests keep it high across the edge.
    task automatic send_access(input func_t fn, input int unsigned r, input fmt_t f,
                               input logic [DATA_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        req_func   <= fn;
        req_reg    <= REG_IDX_W'(r);
        req_format <= f;
        req_value  <= v;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_access(fn, r, f, v);
    endtask

    // Stop sending and let every outstanding response drain, then idle on so
    // the pipeline is empty before anything else changes.
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mode register may only change with nothing in flight.
    task automatic set_mode(input bit w);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.wide   = w;
        cur_wide  = w;
    endtask

    // Mostly write-then-read pairs on a small pool of registers (low and high
    // ends) so tags get adopted, matched and poisoned; the rest is noise over
    // the whole field space.
    task automatic run_random(input int n);
        int          sent;
        int unsigned r;
        int unsigned pick;
        fmt_t        wf;
        fmt_t        rf;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(7);
            if ($urandom_range(3) == 0)
                r = $urandom_range(NUM_REGS - 1);
            else
                r = (pick < 4) ? pick : NUM_REGS - 8 + pick;
            if ($urandom_range(9) < 6)
            begin
                wf = fmt_t'($urandom_range(7));
                if (wf == FMT_UNK)
                    wf = FMT_DBL;
                // pairs want even registers in 32-bit mode; leave some odd ones
                if (!cur_wide && $urandom_range(4) != 0)
                    r = r & ~32'd1;
                send_access(FUNC_WRITE, r, wf, random_value());
                case ($urandom_range(9))
                    0, 1:    rf = FMT_UNINT;
                    2:       rf = FMT_UNK;
                    3, 4:    rf = fmt_t'($urandom_range(7));
                    default: rf = (wf == FMT_UNINT32 || wf == FMT_UNINT64) ? FMT_UNINT : wf;
                endcase
                send_access(FUNC_READ, r, rf, random_value());
                sent += 2;
            end
            else
            begin
                send_access(func_t'($urandom_range(1)), r, fmt_t'($urandom_range(7)),
                            random_value());
                sent += 1;
            end
            // now and then hold off until the pipe has fully drained
            if ($urandom_range(199) == 0)
                wait_idle();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 64-bit mode (reset value)
        send_access(FUNC_READ,  0,  FMT_UNINT,   '1);          // untouched register reads zero
        send_access(FUNC_WRITE, 0,  FMT_SGL,     '1);          // upper half filled with marker
        send_access(FUNC_READ,  0,  FMT_SGL,     '0);
        send_access(FUNC_READ,  0,  FMT_DBL,     '0);          // mismatch: tag goes unknown
        send_access(FUNC_READ,  0,  FMT_UNINT,   '0);          // unknown tag, no NaN for it
        send_access(FUNC_WRITE, 1,  FMT_DBL,     64'h8000_0000_0000_0001);
        send_access(FUNC_READ,  1,  FMT_UNK,     '0);          // takes the stored tag
        send_access(FUNC_READ,  1,  FMT_W32,     '0);
        send_access(FUNC_READ,  1,  FMT_L64,     '0);
        send_access(FUNC_WRITE, 2,  FMT_W32,     '1);
        send_access(FUNC_READ,  2,  FMT_SGL,     '0);
        send_access(FUNC_WRITE, 3,  FMT_UNINT32, 64'h1234_5678_9ABC_DEF0);
        send_access(FUNC_READ,  3,  FMT_UNINT32, '0);          // 32-bit uninterpreted read faults
        send_access(FUNC_WRITE, 31, FMT_UNINT64, '1);
        send_access(FUNC_READ,  31, FMT_L64,     '0);          // fresh tag adopts long
        send_access(FUNC_WRITE, 4,  FMT_UNK,     '1);          // bad write format
        send_access(FUNC_READ,  4,  FMT_SGL,     '0);
        send_access(FUNC_READ,  5,  FMT_UNINT64, '0);

        // 32-bit mode: pairs, odd registers, top of the file
        set_mode(1'b0);
        send_access(FUNC_WRITE, 6,  FMT_DBL,     64'h0123_4567_89AB_CDEF);
        send_access(FUNC_READ,  6,  FMT_DBL,     '0);
        send_access(FUNC_READ,  7,  FMT_SGL,     '0);
        send_access(FUNC_WRITE, 9,  FMT_L64,     '1);          // odd pair write is reserved
        send_access(FUNC_READ,  11, FMT_DBL,     '0);          // odd pair read is reserved
        send_access(FUNC_WRITE, 31, FMT_DBL,     '1);          // last register, no partner
        send_access(FUNC_WRITE, 30, FMT_UNINT64, 64'hFEDC_BA98_7654_3210);
        send_access(FUNC_READ,  30, FMT_UNINT,   '0);

        set_mode(1'b1);
        run_random(325);
        set_mode(1'b0);
        run_random(325);

        set_mode(1'b1);
        send_idle_pct = 45;
        run_random(325);

        set_mode(1'b0);
        send_idle_pct = 0;
        rsp_stall_pct = 45;
        run_random(325);

        set_mode(1'b1);
        send_idle_pct = 32;
        rsp_stall_pct = 32;
        run_random(325);
        set_mode(1'b0);
        run_random(325);

        wait_idle();
        repeat (8) @(posedge clk);
        if (sb.expected_q.size() != 0)
            sb.report("responses never delivered", DATA_W'(sb.expected_q.size()), '0);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
